// File: hw/rtl/ovn1d_pkg.sv
package ovn1d_pkg;

  // Default octave capacity of the pipeline.
  localparam int MAX_OCTAVES_DEF = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED   = 2'd0,
    CFG_OCTAVE = 2'd1,
    CFG_FREQ   = 2'd2
  } cfg_reg_t;

  // Reset values of the registers.
  localparam logic [31:0] SEED_RST   = 32'd0;
  localparam logic [3:0]  OCTAVE_RST = 4'd5;
  localparam logic [23:0] FREQ_RST   = 24'd134218;

  // Lattice hash constants.
  localparam logic [31:0] HASH_X_MUL    = 32'd1619;
  localparam logic [31:0] HASH_SEED_MUL = 32'd31337;
  localparam logic [31:0] HASH_SQ_MUL   = 32'd15731;
  localparam logic [31:0] HASH_SQ_ADD   = 32'd789221;
  localparam logic [31:0] HASH_ADD      = 32'd1376312589;
  localparam int          HASH_SHIFT    = 13;
  localparam logic signed [31:0] HASH_HALF = 32'sh4000_0000;

  // Quotient bits of the final normalizing division.
  localparam int Q_W = 18;

endpackage

// File: hw/rtl/octave_value_noise_1d_top.sv
// Fractal 1D value noise, one sample per beat.
//
// Input stream (s_*): one beat carries a signed 24-bit position.
// Output stream (m_*): one beat carries the signed Q1.15 noise value.
// Configuration (cfg_*): write seed, octave count and base frequency by
// index; write only while the pipeline is empty.
//
// Throughput: one beat per cycle while the receiver does not stall. The
// pipeline is made of six stages of scaling, hashing and blending, one
// accumulate stage per octave, one rounding stage, one stage per quotient
// bit of the restoring divider by 2^K - 1, and the output register.
//
// Reset clears all valid bits and loads the register defaults (seed 0,
// five octaves, base frequency 134218). When the receiver stalls, the
// whole pipeline holds and s_tready drops; no beat is lost or repeated.
module octave_value_noise_1d_top #(
  parameter int MAX_OCTAVES = ovn1d_pkg::MAX_OCTAVES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [23:0]                      s_tdata,   // [23:0] position
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,   // [15:0] noise_value
  input  logic                             cfg_we,
  input  logic [ovn1d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ovn1d_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ovn1d_pkg::*;

  localparam int KW    = $clog2(MAX_OCTAVES + 1);
  localparam int SX_W  = 56 + MAX_OCTAVES;
  localparam int ACC_W = 48 + MAX_OCTAVES;
  localparam int TP_W  = MAX_OCTAVES + 19;
  localparam int NV    = 6 + MAX_OCTAVES + 1 + Q_W + 1;

  // Configuration registers.
  logic [31:0] seed;
  logic [3:0]  octave_count;
  logic [23:0] base_freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= SEED_RST;
      octave_count <= OCTAVE_RST;
      base_freq    <= FREQ_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SEED:   seed         <= cfg_data[31:0];
        CFG_OCTAVE: octave_count <= cfg_data[3:0];
        CFG_FREQ:   base_freq    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Effective octave count, clamped to one..MAX_OCTAVES, and 2^K - 1.
  logic [KW-1:0]          k_eff;
  logic [MAX_OCTAVES-1:0] dv;

  always_comb begin
    if (octave_count == 4'd0) begin
      k_eff = KW'(1);
    end else if (int'(octave_count) > MAX_OCTAVES) begin
      k_eff = KW'(MAX_OCTAVES);
    end else begin
      k_eff = KW'(octave_count);
    end
    dv = MAX_OCTAVES'((32'd1 << k_eff) - 32'd1);
  end

  // Pipeline control: everything advances together unless the output is stalled.
  logic          adv;
  logic [NV-1:0] vld;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], s_tvalid};
    end
  end

  // Stage 1: position times base frequency, seed term of the hash.
  logic signed [47:0] p1;
  logic [31:0]        sm1;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1  <= 48'($signed(s_tdata) * $signed({1'b0, base_freq}));
      sm1 <= seed * HASH_SEED_MUL;
    end
  end

  // Stage 2: per octave, split the scaled position into lattice index and fraction.
  logic signed [SX_W-1:0] sx [MAX_OCTAVES];
  logic [31:0]            n2 [MAX_OCTAVES];
  logic [15:0]            f2 [MAX_OCTAVES];

  always_comb begin
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      sx[i] = SX_W'(p1) <<< i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        n2[i] <= sx[i][55:24] * HASH_X_MUL + sm1;
        f2[i] <= sx[i][23:8];
      end
    end
  end

  // Stage 3: shift-xor both neighbors, square; square the fraction.
  logic [31:0] ma [MAX_OCTAVES];
  logic [31:0] mb [MAX_OCTAVES];
  logic [31:0] m3a [MAX_OCTAVES];
  logic [31:0] m3b [MAX_OCTAVES];
  logic [31:0] q3a [MAX_OCTAVES];
  logic [31:0] q3b [MAX_OCTAVES];
  logic [31:0] ff3 [MAX_OCTAVES];
  logic [17:0] w3 [MAX_OCTAVES];

  always_comb begin
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      ma[i] = (n2[i] << HASH_SHIFT) ^ n2[i];
      mb[i] = ((n2[i] + HASH_X_MUL) << HASH_SHIFT) ^ (n2[i] + HASH_X_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        m3a[i] <= ma[i];
        m3b[i] <= mb[i];
        q3a[i] <= ma[i] * ma[i];
        q3b[i] <= mb[i] * mb[i];
        ff3[i] <= 32'(f2[i]) * 32'(f2[i]);
        w3[i]  <= 18'h30000 - {1'b0, f2[i], 1'b0};
      end
    end
  end

  // Stage 4: polynomial inner term, smoothstep weight.
  logic [31:0] m4a [MAX_OCTAVES];
  logic [31:0] m4b [MAX_OCTAVES];
  logic [31:0] t4a [MAX_OCTAVES];
  logic [31:0] t4b [MAX_OCTAVES];
  logic [15:0] u4 [MAX_OCTAVES];
  logic [49:0] uu [MAX_OCTAVES];

  always_comb begin
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      uu[i] = 50'(ff3[i]) * 50'(w3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        m4a[i] <= m3a[i];
        m4b[i] <= m3b[i];
        t4a[i] <= q3a[i] * HASH_SQ_MUL + HASH_SQ_ADD;
        t4b[i] <= q3b[i] * HASH_SQ_MUL + HASH_SQ_ADD;
        u4[i]  <= uu[i][47:32];
      end
    end
  end

  // Stage 5: finish the hash word and map it to Q1.30.
  logic [31:0]        va [MAX_OCTAVES];
  logic [31:0]        vb [MAX_OCTAVES];
  logic signed [31:0] h5a [MAX_OCTAVES];
  logic signed [31:0] h5b [MAX_OCTAVES];
  logic [15:0]        u5 [MAX_OCTAVES];

  always_comb begin
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      va[i] = m4a[i] * t4a[i] + HASH_ADD;
      vb[i] = m4b[i] * t4b[i] + HASH_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        h5a[i] <= HASH_HALF - $signed({1'b0, va[i][30:0]});
        h5b[i] <= HASH_HALF - $signed({1'b0, vb[i][30:0]});
        u5[i]  <= u4[i];
      end
    end
  end

  // Stage 6: blend the two lattice values.
  logic signed [47:0] s6 [MAX_OCTAVES];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MAX_OCTAVES; i++) begin
        s6[i] <= 48'(h5a[i] * $signed({1'b0, 17'h10000 - {1'b0, u5[i]}}))
               + 48'(h5b[i] * $signed({1'b0, u5[i]}));
      end
    end
  end

  // Accumulate chain, Horner form: acc = 2 * acc + s_j for active octaves.
  logic signed [ACC_W-1:0] acc_c [MAX_OCTAVES];
  logic signed [47:0]      s_c [MAX_OCTAVES][MAX_OCTAVES];

  for (genvar j = 0; j < MAX_OCTAVES; j++) begin : g_acc
    logic signed [ACC_W-1:0] a_in;
    logic signed [47:0]      s_in [MAX_OCTAVES];

    if (j == 0) begin : g_first
      assign a_in = '0;
      assign s_in = s6;
    end else begin : g_next
      assign a_in = acc_c[j-1];
      assign s_in = s_c[j-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s_c[j] <= s_in;
        if (j < int'(k_eff)) begin
          acc_c[j] <= (a_in <<< 1) + ACC_W'(s_in[j]);
        end else begin
          acc_c[j] <= a_in;
        end
      end
    end
  end

  // Rounding stage: add half the divisor, drop 31 bits, offset by 2^16 * d
  // so the dividend is never negative.
  logic signed [ACC_W-1:0] dv_a;
  logic signed [ACC_W-1:0] t_full;
  logic [TP_W-1:0]         tp;

  always_comb begin
    dv_a   = $signed(ACC_W'(dv));
    t_full = ((acc_c[MAX_OCTAVES-1] + (dv_a <<< 30)) >>> 31) + (dv_a <<< 16);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tp <= t_full[TP_W-1:0];
    end
  end

  // Restoring divider by 2^K - 1, one quotient bit per stage.
  logic [TP_W-1:0] rem_c [Q_W];
  logic [Q_W-1:0]  q_c [Q_W];

  for (genvar d = 0; d < Q_W; d++) begin : g_div
    localparam int B = Q_W - 1 - d;
    logic [TP_W-1:0] r_in;
    logic [Q_W-1:0]  q_in;
    logic [TP_W-1:0] dsh;

    if (d == 0) begin : g_first
      assign r_in = tp;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_c[d-1];
      assign q_in = q_c[d-1];
    end

    assign dsh = TP_W'(dv) << B;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (r_in >= dsh) begin
          rem_c[d] <= r_in - dsh;
          q_c[d]   <= q_in | (Q_W'(1) << B);
        end else begin
          rem_c[d] <= r_in;
          q_c[d]   <= q_in;
        end
      end
    end
  end

  // Output register: remove the offset and saturate to Q1.15.
  logic signed [Q_W:0] r_fin;

  assign r_fin = $signed({1'b0, q_c[Q_W-1]}) - $signed((Q_W+1)'(32'h10000));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (r_fin > $signed((Q_W+1)'(32'h7FFF))) begin
        m_tdata <= 16'h7FFF;
      end else if (r_fin < -$signed((Q_W+1)'(32'h8000))) begin
        m_tdata <= 16'h8000;
      end else begin
        m_tdata <= r_fin[15:0];
      end
    end
  end

  // An accepted beat lands in the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted beat did not enter the pipeline");

  // A stalled output freezes every stage.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (vld == $past(vld)))
    else $error("pipeline moved during a stall");

  // Offset quotient stays within one unit of full scale.
  a_qrange: assert property (@(posedge clk) disable iff (rst)
    vld[NV-2] |-> (q_c[Q_W-1] <= Q_W'(32'h20001)))
    else $error("quotient out of range");

endmodule
